// File: rtl/mra_pkg.sv
// Shared types and codes for the free-rectangle atlas allocator.
// No dependencies; imported by mra_mem, the top level and the checker.
package mra_pkg;

  // Fraction bits of every Q1.16 quantity on the ports and in the registers
  localparam int FRAC_BITS = 16;

  // One free-table entry: origin and extent, unsigned fixed point
  typedef struct packed {
    logic [17:0] ox;
    logic [17:0] oy;
    logic [16:0] w;
    logic [16:0] h;
  } free_rect_t;

  // Command opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  // Result status codes
  localparam logic [2:0] STAT_PLACED     = 3'd0;
  localparam logic [2:0] STAT_NO_FIT     = 3'd1;
  localparam logic [2:0] STAT_OVERFLOW   = 3'd2;
  localparam logic [2:0] STAT_FAILED     = 3'd3;
  localparam logic [2:0] STAT_RESET_DONE = 3'd4;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MIN_X  = 3'd0;
  localparam logic [2:0] REG_MIN_Y  = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_PAD    = 3'd4;
  localparam logic [2:0] REG_SCALE  = 3'd5;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCW,    // scale width
    ST_SCH,    // scale height
    ST_PAD,    // pad both sides
    ST_AREA,   // padded area product
    ST_AREA2,
    ST_SRD,    // scan: read entry
    ST_SEV,    // scan: leftovers, entry area
    ST_SCMP,   // scan: rank against best
    ST_CRD,    // cut: read entry
    ST_CEV,    // cut: overlap test
    ST_CSWR,   // cut: read last for swap
    ST_CSWW,   // cut: write swapped entry
    ST_CPC,    // cut: emit pieces
    ST_PINIT,  // prune setup
    ST_PRA,    // prune: read outer entry
    ST_PLA,    // prune: latch outer entry
    ST_PRB,    // prune: read inner entry
    ST_PCB,    // prune: containment test
    ST_PSWR,   // prune: read last for swap
    ST_PSWW,   // prune: write swapped entry
    ST_DONE
  } mra_state_t;

endpackage

// File: rtl/mra_mul.sv
// Shared 18x18 unsigned multiplier with registered product.
// No dependencies; used by the allocator sequencer.
module mra_mul (
  input  logic        clk,
  input  logic [17:0] mul_a,
  input  logic [17:0] mul_b,
  output logic [35:0] mul_p
);
  logic [35:0] prod;
  logic [35:0] prod_r;

  assign prod = mul_a * mul_b;

  // one multiply per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= prod;
  end

  assign mul_p = prod_r;
endmodule

// File: rtl/mra_mem.sv
// Free-rectangle table: one write port, one registered read port.
// Depends on mra_pkg for the entry type.
module mra_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  mra_pkg::free_rect_t     wdata,
  input  logic [AW-1:0]           raddr,
  output mra_pkg::free_rect_t     rdata
);
  import mra_pkg::*;

  free_rect_t mem [DEPTH];
  free_rect_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/maxrects_rect_allocator.sv
// Top level of the atlas allocator: APB registers, sequencer, table, multiplier.
// Depends on mra_pkg, mra_mul and mra_mem.
//
// A start command answers in the cycle after it is taken, as does a place command
// while the attempt has already failed; busy stays low for both. A place
// command keeps busy high while one sequencer drives the single shared
// multiplier and the free table, which has one write and one read port: it
// sizes the request, scans every table entry for the best fit, cuts the used
// area out of each overlapping entry, then prunes entries held inside others.
// The result appears on the out_ ports for exactly one cycle with out_valid high
// and cannot be held off.
module maxrects_rect_allocator #(
  parameter int FREE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [16:0] in_want_width,
  input  logic [16:0] in_want_height,
  // result channel
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [17:0] out_place_x,
  output logic [17:0] out_place_y,
  output logic [16:0] out_placed_width,
  output logic [16:0] out_placed_height,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mra_pkg::*;

  localparam int IDX_W = $clog2(FREE_SLOTS);
  localparam int CNT_W = $clog2(FREE_SLOTS + 1);

  // saturate a scaled side to [1, 17'h1FFFF]
  function automatic logic [16:0] sat_side(input logic [35:0] p);
    logic [35:0] sc;
    begin
      sc = p >> FRAC_BITS;
      if (sc > 36'h1FFFF) sat_side = 17'h1FFFF;
      else if (sc == 36'd0) sat_side = 17'd1;
      else sat_side = sc[16:0];
    end
  endfunction

  // configuration registers
  logic [16:0] min_x_r, min_y_r, wid_r, hgt_r, scale_r;
  logic [15:0] pad_r;
  logic        cfg_wr;

  mra_state_t  state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, b_r, b_nxt;
  logic        failed_r, failed_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [16:0] want_w_r, want_w_nxt, want_h_r, want_h_nxt;
  logic [16:0] w_r, w_nxt, h_r, h_nxt;
  logic [17:0] pw_r, pw_nxt, ph_r, ph_nxt;
  logic [35:0] pa_r, pa_nxt, ba_r, ba_nxt;
  logic        found_r, found_nxt, fit_r, fit_nxt;
  logic [16:0] bs_r, bs_nxt, bl_r, bl_nxt, s_r, s_nxt, l_r, l_nxt;
  logic [17:0] box_r, box_nxt, boy_r, boy_nxt;
  free_rect_t  cur_r, cur_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [17:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [16:0] out_w_r, out_w_nxt, out_h_r, out_h_nxt;

  // shared unit and table ports
  logic [17:0] mul_a, mul_b;
  logic [35:0] mul_p;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  free_rect_t  mem_wdata, rd_q;

  mra_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p));

  mra_mem #(.DEPTH(FREE_SLOTS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rd_q)
  );

  // APB: always ready, write on access phase
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= 17'd0;
      min_y_r <= 17'd0;
      wid_r   <= 17'h10000;
      hgt_r   <= 17'h10000;
      pad_r   <= 16'd0;
      scale_r <= 17'h10000;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MIN_X:  min_x_r <= pwdata[16:0];
        REG_MIN_Y:  min_y_r <= pwdata[16:0];
        REG_WIDTH:  wid_r   <= pwdata[16:0];
        REG_HEIGHT: hgt_r   <= pwdata[16:0];
        REG_PAD:    pad_r   <= pwdata[15:0];
        REG_SCALE:  scale_r <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MIN_X:  prdata = {15'd0, min_x_r};
      REG_MIN_Y:  prdata = {15'd0, min_y_r};
      REG_WIDTH:  prdata = {15'd0, wid_r};
      REG_HEIGHT: prdata = {15'd0, hgt_r};
      REG_PAD:    prdata = {16'd0, pad_r};
      REG_SCALE:  prdata = {15'd0, scale_r};
      default:    prdata = 32'd0;
    endcase
  end

  // geometry helpers
  logic [16:0] pad2;
  logic [18:0] ur, ut, c_fr, c_ft, q_fr, q_ft;
  logic [16:0] lx, ly;
  logic [35:0] area;
  logic        upd, fnd, overlap, held_in, pc_ok;
  logic [CNT_W-1:0] last;
  free_rect_t  piece;

  assign pad2 = {pad_r, 1'b0};
  assign ur   = {1'b0, box_r} + {1'b0, pw_r};
  assign ut   = {1'b0, boy_r} + {1'b0, ph_r};
  assign c_fr = {1'b0, cur_r.ox} + {2'b0, cur_r.w};
  assign c_ft = {1'b0, cur_r.oy} + {2'b0, cur_r.h};
  assign q_fr = {1'b0, rd_q.ox} + {2'b0, rd_q.w};
  assign q_ft = {1'b0, rd_q.oy} + {2'b0, rd_q.h};
  assign lx   = rd_q.w - pw_r[16:0];
  assign ly   = rd_q.h - ph_r[16:0];
  assign area = mul_p - pa_r;
  assign last = count_r - CNT_W'(1);

  assign upd = fit_r && (!found_r || s_r < bs_r || (s_r == bs_r && l_r < bl_r) ||
               (s_r == bs_r && l_r == bl_r && area < ba_r));
  assign fnd = found_r | upd;

  assign overlap = ({1'b0, box_r} < q_fr) && (ur > {1'b0, rd_q.ox}) &&
                   ({1'b0, boy_r} < q_ft) && (ut > {1'b0, rd_q.oy});
  assign held_in = (cur_r.ox >= rd_q.ox) && (cur_r.oy >= rd_q.oy) &&
                   (c_fr <= q_fr) && (c_ft <= q_ft);

  // the four pieces left around the used area
  always_comb begin
    piece = cur_r;
    pc_ok = 1'b0;
    case (k_r)
      2'd0: begin
        pc_ok   = box_r > cur_r.ox;
        piece.w = 17'(box_r - cur_r.ox);
      end
      2'd1: begin
        pc_ok    = ur < c_fr;
        piece.ox = ur[17:0];
        piece.w  = 17'(c_fr - ur);
      end
      2'd2: begin
        pc_ok   = boy_r > cur_r.oy;
        piece.h = 17'(boy_r - cur_r.oy);
      end
      default: begin
        pc_ok    = ut < c_ft;
        piece.oy = ut[17:0];
        piece.h  = 17'(c_ft - ut);
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    i_nxt      = i_r;
    b_nxt      = b_r;
    k_nxt      = k_r;
    want_w_nxt = want_w_r;
    want_h_nxt = want_h_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    pw_nxt     = pw_r;
    ph_nxt     = ph_r;
    pa_nxt     = pa_r;
    found_nxt  = found_r;
    fit_nxt    = fit_r;
    bs_nxt     = bs_r;
    bl_nxt     = bl_r;
    ba_nxt     = ba_r;
    s_nxt      = s_r;
    l_nxt      = l_r;
    box_nxt    = box_r;
    boy_nxt    = boy_r;
    cur_nxt    = cur_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_x_nxt  = out_x_r;
    out_y_nxt  = out_y_r;
    out_w_nxt  = out_w_r;
    out_h_nxt  = out_h_r;
    mul_a      = 18'd0;
    mul_b      = 18'd0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = cur_r;
    mem_raddr  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == OP_START) begin
            mem_we    = 1'b1;
            mem_wdata = '{ox: {1'b0, min_x_r}, oy: {1'b0, min_y_r}, w: wid_r, h: hgt_r};
            count_nxt = (wid_r != 17'd0 && hgt_r != 17'd0) ? CNT_W'(1) : '0;
            failed_nxt = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_RESET_DONE;
            out_x_nxt = '0; out_y_nxt = '0; out_w_nxt = '0; out_h_nxt = '0;
          end else if (failed_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FAILED;
            out_x_nxt = '0; out_y_nxt = '0; out_w_nxt = '0; out_h_nxt = '0;
          end else begin
            want_w_nxt = in_want_width;
            want_h_nxt = in_want_height;
            state_nxt  = ST_SCW;
          end
        end
      end
      ST_SCW: begin
        mul_a = {1'b0, want_w_r};
        mul_b = {1'b0, scale_r};
        state_nxt = ST_SCH;
      end
      ST_SCH: begin
        w_nxt = sat_side(mul_p);
        mul_a = {1'b0, want_h_r};
        mul_b = {1'b0, scale_r};
        state_nxt = ST_PAD;
      end
      ST_PAD: begin
        h_nxt  = sat_side(mul_p);
        pw_nxt = {1'b0, w_r} + {1'b0, pad2};
        ph_nxt = {1'b0, sat_side(mul_p)} + {1'b0, pad2};
        state_nxt = ST_AREA;
      end
      ST_AREA: begin
        mul_a = pw_r;
        mul_b = ph_r;
        state_nxt = ST_AREA2;
      end
      ST_AREA2: begin
        pa_nxt    = mul_p;
        found_nxt = 1'b0;
        i_nxt     = '0;
        if (count_r == '0) begin
          failed_nxt     = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NO_FIT;
          out_x_nxt = '0; out_y_nxt = '0; out_w_nxt = '0; out_h_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SRD;
        end
      end
      // best short side, then long side, then area waste
      ST_SRD: begin
        mem_raddr = i_r;
        state_nxt = ST_SEV;
      end
      ST_SEV: begin
        cur_nxt = rd_q;
        fit_nxt = ({1'b0, rd_q.w} >= pw_r) && ({1'b0, rd_q.h} >= ph_r);
        s_nxt   = (lx < ly) ? lx : ly;
        l_nxt   = (lx < ly) ? ly : lx;
        mul_a   = {1'b0, rd_q.w};
        mul_b   = {1'b0, rd_q.h};
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        if (upd) begin
          found_nxt = 1'b1;
          bs_nxt  = s_r;
          bl_nxt  = l_r;
          ba_nxt  = area;
          box_nxt = cur_r.ox;
          boy_nxt = cur_r.oy;
        end
        if (CNT_W'(i_r) == last) begin
          if (!fnd) begin
            failed_nxt     = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_NO_FIT;
            out_x_nxt = '0; out_y_nxt = '0; out_w_nxt = '0; out_h_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = last[IDX_W-1:0];
            state_nxt = ST_CRD;
          end
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_SRD;
        end
      end
      // cut the used area out of every overlapping entry, last to first
      ST_CRD: begin
        mem_raddr = i_r;
        state_nxt = ST_CEV;
      end
      ST_CEV: begin
        cur_nxt = rd_q;
        k_nxt   = 2'd0;
        if (overlap) begin
          if (CNT_W'(i_r) < last) begin
            state_nxt = ST_CSWR;
          end else begin
            count_nxt = last;
            state_nxt = ST_CPC;
          end
        end else if (i_r == '0) begin
          state_nxt = ST_PINIT;
        end else begin
          i_nxt     = i_r - IDX_W'(1);
          state_nxt = ST_CRD;
        end
      end
      ST_CSWR: begin
        mem_raddr = last[IDX_W-1:0];
        state_nxt = ST_CSWW;
      end
      ST_CSWW: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = rd_q;
        count_nxt = last;
        state_nxt = ST_CPC;
      end
      ST_CPC: begin
        if (pc_ok && count_r >= CNT_W'(FREE_SLOTS)) begin
          failed_nxt     = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OVERFLOW;
          out_x_nxt = '0; out_y_nxt = '0; out_w_nxt = '0; out_h_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          if (pc_ok) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[IDX_W-1:0];
            mem_wdata = piece;
            count_nxt = count_r + CNT_W'(1);
          end
          if (k_r == 2'd3) begin
            if (i_r == '0) begin
              state_nxt = ST_PINIT;
            end else begin
              i_nxt     = i_r - IDX_W'(1);
              state_nxt = ST_CRD;
            end
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      // drop entries held inside another entry, last to first
      ST_PINIT: begin
        if (count_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = last[IDX_W-1:0];
          state_nxt = ST_PRA;
        end
      end
      ST_PRA: begin
        mem_raddr = i_r;
        state_nxt = ST_PLA;
      end
      ST_PLA: begin
        cur_nxt   = rd_q;
        b_nxt     = '0;
        state_nxt = ST_PRB;
      end
      ST_PRB: begin
        if (b_r >= count_r) begin
          if (i_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            i_nxt     = i_r - IDX_W'(1);
            state_nxt = ST_PRA;
          end
        end else if (b_r == CNT_W'(i_r)) begin
          b_nxt = b_r + CNT_W'(1);
        end else begin
          mem_raddr = b_r[IDX_W-1:0];
          state_nxt = ST_PCB;
        end
      end
      ST_PCB: begin
        if (held_in) begin
          if (CNT_W'(i_r) < last) begin
            state_nxt = ST_PSWR;
          end else begin
            count_nxt = last;
            if (i_r == '0) begin
              state_nxt = ST_DONE;
            end else begin
              i_nxt     = i_r - IDX_W'(1);
              state_nxt = ST_PRA;
            end
          end
        end else begin
          b_nxt     = b_r + CNT_W'(1);
          state_nxt = ST_PRB;
        end
      end
      ST_PSWR: begin
        mem_raddr = last[IDX_W-1:0];
        state_nxt = ST_PSWW;
      end
      ST_PSWW: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = rd_q;
        count_nxt = last;
        if (i_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = i_r - IDX_W'(1);
          state_nxt = ST_PRA;
        end
      end
      ST_DONE: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_PLACED;
        out_x_nxt = 18'({1'b0, box_r} + {3'b0, pad_r});
        out_y_nxt = 18'({1'b0, boy_r} + {3'b0, pad_r});
        out_w_nxt = w_r;
        out_h_nxt = h_r;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    b_r      <= b_nxt;
    k_r      <= k_nxt;
    want_w_r <= want_w_nxt;
    want_h_r <= want_h_nxt;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    pw_r     <= pw_nxt;
    ph_r     <= ph_nxt;
    pa_r     <= pa_nxt;
    found_r  <= found_nxt;
    fit_r    <= fit_nxt;
    bs_r     <= bs_nxt;
    bl_r     <= bl_nxt;
    ba_r     <= ba_nxt;
    s_r      <= s_nxt;
    l_r      <= l_nxt;
    box_r    <= box_nxt;
    boy_r    <= boy_nxt;
    cur_r    <= cur_nxt;
    out_status_r <= out_status_nxt;
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    out_w_r  <= out_w_nxt;
    out_h_r  <= out_h_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_place_x       = out_x_r;
  assign out_place_y       = out_y_r;
  assign out_placed_width  = out_w_r;
  assign out_placed_height = out_h_r;
endmodule

// File: rtl/mra_chk.sv
// Port-level checks for the allocator, bound to the top level.
// Depends on mra_pkg for status and opcode codes.
module mra_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_opcode,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [17:0] out_place_x,
  input logic [17:0] out_place_y,
  input logic [16:0] out_placed_width,
  input logic [16:0] out_placed_height,
  input logic        pready
);
  import mra_pkg::*;

  // a start beat answers with reset done on the next cycle
  a_start_ack: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == OP_START |=> out_valid && out_status == STAT_RESET_DONE)
    else $error("start not acknowledged");

  // a place beat either starts work or answers at once
  a_place_prog: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == OP_PLACE |=> busy || out_valid)
    else $error("place beat dropped");

  // results other than placed carry no geometry
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_PLACED |->
      out_place_x == 18'd0 && out_place_y == 18'd0 &&
      out_placed_width == 17'd0 && out_placed_height == 17'd0)
    else $error("geometry on failed result");

  // a placed result has non-empty content
  a_placed_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_PLACED |->
      out_placed_width != 17'd0 && out_placed_height != 17'd0)
    else $error("empty placed size");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");
endmodule

bind maxrects_rect_allocator mra_chk u_mra_chk (.*);
